@@ src/seirs_cell_update_defines.svh @@
// ----------------------------------------------------------------------------
// SEIRS cell update assertion macros
// Shared concurrent assertion forms, clocked on clk_i, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SEIRS_CELL_UPDATE_DEFINES_SVH
`define SEIRS_CELL_UPDATE_DEFINES_SVH

// Same-cycle implication.
`define SEIRS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("seirs check failed: same-cycle implication");

// Next-cycle implication.
`define SEIRS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("seirs check failed: next-cycle implication");

`endif

@@ src/seirs_pkg.sv @@
// ----------------------------------------------------------------------------
// SEIRS package
// Widths, status codes, register indexes and reset values of the cell update.
// ----------------------------------------------------------------------------
package seirs_pkg;

  localparam int unsigned DAY_W   = 16;
  localparam int unsigned Q_W     = 16;
  localparam int unsigned NBR_W   = 8;
  localparam int unsigned CNT_W   = $clog2(NBR_W + 1);
  localparam int unsigned CFG_IDX_W = 8;

  // One power of the escape factor per possible neighbour count (1..NBR_W)
  localparam int unsigned POW_DEPTH = NBR_W;
  localparam int unsigned POW_IDX_W = $clog2(POW_DEPTH);

  localparam logic [DAY_W-1:0] DAY_MAX = {DAY_W{1'b1}};

  typedef enum logic [1:0] {
    ST_SUSCEPTIBLE = 2'd0,
    ST_EXPOSED     = 2'd1,
    ST_INFECTIOUS  = 2'd2,
    ST_RECOVERED   = 2'd3
  } status_e;

  localparam logic [CFG_IDX_W-1:0] CFG_INCUBATION = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_CONTAGIOUS = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_IMMUNITY   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE     = CFG_IDX_W'(3);

  localparam logic [DAY_W-1:0] INCUBATION_RST = DAY_W'(5);
  localparam logic [DAY_W-1:0] CONTAGIOUS_RST = DAY_W'(7);
  localparam logic [DAY_W-1:0] IMMUNITY_RST   = DAY_W'(0);
  localparam logic [Q_W-1:0]   ESCAPE_RST     = Q_W'(39750);

endpackage

@@ src/seirs_cell_update.sv @@
// ----------------------------------------------------------------------------
// SEIRS cell update
// One daily status step of one grid agent, three-stage pipeline.
// ----------------------------------------------------------------------------
// Takes one agent record per cycle while in_ready_o is high and returns one
// updated record per record, in order, through the stage 1, stage 2 and
// output registers. The infection chance uses powers q^1..q^8 of escape_factor
// that sit in a small table; a shared 16x16 multiplier rebuilds that table
// entry by entry after reset and after each write of escape_factor, and
// in_ready_o stays low while it does. Configuration writes are always taken
// (cfg_ready_o is tied high) and must only come while no record is in flight.
module seirs_cell_update (
  input  logic                              clk_i,
  input  logic                              rst_ni,

  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [seirs_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [seirs_pkg::DAY_W-1:0]       cfg_data_i,

  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [1:0]                        status_i,
  input  logic [seirs_pkg::DAY_W-1:0]       days_in_status_i,
  input  logic [seirs_pkg::NBR_W-1:0]       neighbour_mask_i,
  input  logic [seirs_pkg::Q_W-1:0]         random_value_i,

  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [1:0]                        new_status_o,
  output logic [seirs_pkg::DAY_W-1:0]       new_days_o,
  output logic                              is_sick_o,
  output logic                              is_contagious_o
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [seirs_pkg::DAY_W-1:0] incubation_q;
  logic [seirs_pkg::DAY_W-1:0] contagious_q;
  logic [seirs_pkg::DAY_W-1:0] immunity_q;
  logic [seirs_pkg::Q_W-1:0]   escape_q;
  logic                        cfg_xfer;
  logic                        escape_wr;

  assign cfg_ready_o = 1'b1;
  assign cfg_xfer    = cfg_valid_i && cfg_ready_o;
  assign escape_wr   = cfg_xfer && (cfg_index_i == seirs_pkg::CFG_ESCAPE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      incubation_q <= seirs_pkg::INCUBATION_RST;
      contagious_q <= seirs_pkg::CONTAGIOUS_RST;
      immunity_q   <= seirs_pkg::IMMUNITY_RST;
      escape_q     <= seirs_pkg::ESCAPE_RST;
    end else if (cfg_xfer) begin
      case (cfg_index_i)
        seirs_pkg::CFG_INCUBATION: incubation_q <= cfg_data_i;
        seirs_pkg::CFG_CONTAGIOUS: contagious_q <= cfg_data_i;
        seirs_pkg::CFG_IMMUNITY:   immunity_q   <= cfg_data_i;
        seirs_pkg::CFG_ESCAPE:     escape_q     <= cfg_data_i;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline flow control: a stage loads when empty or when it drains
  // --------------------------------------------------------------------------
  logic s1_valid_q, s2_valid_q, out_valid_q;
  logic s1_ready, s2_ready, s3_ready;
  logic tbl_busy;
  logic in_xfer;

  assign s3_ready   = !out_valid_q || out_ready_i;
  assign s2_ready   = !s2_valid_q  || s3_ready;
  assign s1_ready   = !s1_valid_q  || s2_ready;
  assign in_ready_o = s1_ready && !tbl_busy;
  assign in_xfer    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= in_xfer;
      end
      if (s2_ready) begin
        s2_valid_q <= s1_valid_q;
      end
      if (s3_ready) begin
        out_valid_q <= s2_valid_q;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: count infectious neighbours, advance the day count (saturating)
  // --------------------------------------------------------------------------
  logic [seirs_pkg::CNT_W-1:0] nbr_cnt;
  logic [seirs_pkg::DAY_W-1:0] days_inc;

  logic [1:0]                  s1_status_q;
  logic [seirs_pkg::DAY_W-1:0] s1_days_q;
  logic [seirs_pkg::CNT_W-1:0] s1_cnt_q;
  logic [seirs_pkg::Q_W-1:0]   s1_rnd_q;

  always_comb begin
    nbr_cnt = '0;
    for (int i = 0; i < seirs_pkg::NBR_W; i++) begin
      nbr_cnt = nbr_cnt + seirs_pkg::CNT_W'(neighbour_mask_i[i]);
    end
  end

  assign days_inc = (days_in_status_i == seirs_pkg::DAY_MAX) ? days_in_status_i
                                                             : days_in_status_i + 1'b1;

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_status_q <= status_i;
      s1_days_q   <= days_inc;
      s1_cnt_q    <= nbr_cnt;
      s1_rnd_q    <= random_value_i;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: infection draw against 1 - q^n, duration checks
  // --------------------------------------------------------------------------
  logic [seirs_pkg::POW_IDX_W-1:0] pow_idx;
  logic [seirs_pkg::Q_W-1:0]       pow_n;
  logic [seirs_pkg::Q_W:0]         p_infect;
  logic                            infect;
  logic                            go_d;

  logic [1:0]                  s2_status_q;
  logic [seirs_pkg::DAY_W-1:0] s2_days_q;
  logic                        s2_go_q;

  // Entry k holds q^(k+1); a count of zero is masked below
  assign pow_idx = seirs_pkg::POW_IDX_W'(s1_cnt_q - 1'b1);

  seirs_pow_table u_pow_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .restart_i (escape_wr),
    .escape_i  (escape_q),
    .rd_idx_i  (pow_idx),
    .busy_o    (tbl_busy),
    .rd_pow_o  (pow_n)
  );

  // Chance of infection in unsigned Q1.16: 1.0 - q^n
  assign p_infect = {1'b1, {seirs_pkg::Q_W{1'b0}}} - {1'b0, pow_n};
  assign infect   = (s1_cnt_q != '0) && ({1'b0, s1_rnd_q} < p_infect);

  always_comb begin
    case (seirs_pkg::status_e'(s1_status_q))
      seirs_pkg::ST_SUSCEPTIBLE: go_d = infect;
      seirs_pkg::ST_EXPOSED:     go_d = (s1_days_q >= incubation_q);
      seirs_pkg::ST_INFECTIOUS:  go_d = (s1_days_q >= contagious_q);
      seirs_pkg::ST_RECOVERED:   go_d = (immunity_q != '0) && (s1_days_q >= immunity_q);
      default:                   go_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_valid_q) begin
      s2_status_q <= s1_status_q;
      s2_days_q   <= s1_days_q;
      s2_go_q     <= go_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: apply the transition and hold the result for the consumer.
  // Every transition moves to the next code (recovered wraps to susceptible).
  // --------------------------------------------------------------------------
  logic [1:0]                  st_next;
  logic [seirs_pkg::DAY_W-1:0] days_next;

  logic [1:0]                  out_status_q;
  logic [seirs_pkg::DAY_W-1:0] out_days_q;
  logic                        out_sick_q;
  logic                        out_cont_q;

  assign st_next   = s2_go_q ? s2_status_q + 1'b1 : s2_status_q;
  assign days_next = s2_go_q ? '0 : s2_days_q;

  always_ff @(posedge clk_i) begin
    if (s3_ready && s2_valid_q) begin
      out_status_q <= st_next;
      out_days_q   <= days_next;
      out_sick_q   <= (st_next == seirs_pkg::ST_EXPOSED) ||
                      (st_next == seirs_pkg::ST_INFECTIOUS);
      out_cont_q   <= (st_next == seirs_pkg::ST_INFECTIOUS);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign new_status_o    = out_status_q;
  assign new_days_o      = out_days_q;
  assign is_sick_o       = out_sick_q;
  assign is_contagious_o = out_cont_q;

endmodule

@@ src/seirs_pow_table.sv @@
// ----------------------------------------------------------------------------
// SEIRS escape power table
// Holds q^1..q^8 of the escape factor, rebuilt by one shared multiplier.
// ----------------------------------------------------------------------------
module seirs_pow_table (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             restart_i,
  input  logic [seirs_pkg::Q_W-1:0]        escape_i,
  input  logic [seirs_pkg::POW_IDX_W-1:0]  rd_idx_i,
  output logic                             busy_o,
  output logic [seirs_pkg::Q_W-1:0]        rd_pow_o
);

  localparam logic [seirs_pkg::POW_IDX_W-1:0] POW_LAST =
    seirs_pkg::POW_IDX_W'(seirs_pkg::POW_DEPTH - 1);

  logic [seirs_pkg::Q_W-1:0]       pow_q [seirs_pkg::POW_DEPTH];
  logic [seirs_pkg::Q_W-1:0]       acc_q;
  logic [seirs_pkg::Q_W-1:0]       pow_d;
  logic [2*seirs_pkg::Q_W-1:0]     prod;
  logic [seirs_pkg::POW_IDX_W-1:0] step_q;
  logic                            busy_q;

  // First entry is q itself; each later one truncates the product
  assign prod  = acc_q * escape_i;
  assign pow_d = (step_q == '0) ? escape_i : prod[2*seirs_pkg::Q_W-1:seirs_pkg::Q_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      step_q <= '0;
    end else if (restart_i) begin
      busy_q <= 1'b1;
      step_q <= '0;
    end else if (busy_q) begin
      step_q <= step_q + 1'b1;
      if (step_q == POW_LAST) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q && !restart_i) begin
      pow_q[step_q] <= pow_d;
      acc_q         <= pow_d;
    end
  end

  assign busy_o   = busy_q;
  assign rd_pow_o = pow_q[rd_idx_i];

endmodule

@@ src/seirs_checker.sv @@
// ----------------------------------------------------------------------------
// SEIRS cell update checker
// Port-level assertions on the cell update, attached by bind.
// ----------------------------------------------------------------------------
`include "seirs_cell_update_defines.svh"

module seirs_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              cfg_valid_i,
  input logic                              cfg_ready_o,
  input logic [seirs_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input logic                              in_ready_o,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic [1:0]                        new_status_o,
  input logic [seirs_pkg::DAY_W-1:0]       new_days_o,
  input logic                              is_sick_o,
  input logic                              is_contagious_o
);

  logic out_exposed;
  logic out_infectious;
  logic escape_xfer;

  assign out_exposed    = (new_status_o == seirs_pkg::ST_EXPOSED);
  assign out_infectious = (new_status_o == seirs_pkg::ST_INFECTIOUS);
  assign escape_xfer    = cfg_valid_i && cfg_ready_o &&
                          (cfg_index_i == seirs_pkg::CFG_ESCAPE);

  // Flags follow the reported status
  `SEIRS_ASSERT_IMP(a_contagious_flag, out_valid_o, is_contagious_o == out_infectious)
  `SEIRS_ASSERT_IMP(a_sick_flag, out_valid_o, is_sick_o == (out_exposed || out_infectious))

  // A new escape factor blocks records while the power table rebuilds
  `SEIRS_ASSERT_NXT(a_escape_blocks_input, escape_xfer, !in_ready_o)

  // A stalled result holds
  `SEIRS_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(new_status_o) && $stable(new_days_o))

endmodule

bind seirs_cell_update seirs_checker u_seirs_checker (.*);

@@ tb/seirs_cell_update_tb.sv @@
// ----------------------------------------------------------------------------
// SEIRS cell update testbench
// Streams agent records through the cell update with random source gaps and
// sink stalls. Each result is compared field by field with a typed-in result
// or a local model of the daily step, kept in step with every register write.
// A short directed table (counts at the limits, infection boundaries, zero and
// maximum durations, zero escape factor) runs first, then random phases, each
// under freshly drawn register settings.
// ----------------------------------------------------------------------------
module seirs_cell_update_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import seirs_pkg::*;

  localparam int unsigned CLK_HALF       = 10;
  localparam int unsigned RESET_CYCLES   = 4;
  localparam int unsigned MAX_GAP        = 13;
  localparam int unsigned RANDOM_PHASES  = 10;
  localparam int unsigned PHASE_RECORDS  = 100;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned WATCHDOG_LIMIT = 2000;

  // One agent record as it enters the block
  typedef struct packed {
    status_e              st;
    logic [DAY_W-1:0]     days;
    logic [NBR_W-1:0]     mask;
    logic [Q_W-1:0]       rnd;
  } agent_rec_t;

  // One updated record as it leaves the block
  typedef struct packed {
    status_e              st;
    logic [DAY_W-1:0]     days;
    logic                 sick;
    logic                 contagious;
  } agent_result_t;

  typedef struct packed {
    logic [DAY_W-1:0]     incubation;
    logic [DAY_W-1:0]     contagious;
    logic [DAY_W-1:0]     immunity;
    logic [Q_W-1:0]       escape;
  } cfg_set_t;

  // Directed row: register setting to use, the record, and a typed-in result
  // where one is given (typed = 0 means: ask the model)
  typedef struct packed {
    logic [1:0]           setting;
    agent_rec_t           rec;
    logic                 typed;
    agent_result_t        res;
  } dir_row_t;

  logic                 clk_i            = 1'b0;
  logic                 rst_ni           = 1'b0;

  logic                 cfg_valid_i      = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i      = '0;
  logic [DAY_W-1:0]     cfg_data_i       = '0;

  logic                 in_valid_i       = 1'b0;
  logic                 in_ready_o;
  logic [1:0]           status_i         = '0;
  logic [DAY_W-1:0]     days_in_status_i = '0;
  logic [NBR_W-1:0]     neighbour_mask_i = '0;
  logic [Q_W-1:0]       random_value_i   = '0;

  logic                 out_valid_o;
  logic                 out_ready_i      = 1'b0;
  logic [1:0]           new_status_o;
  logic [DAY_W-1:0]     new_days_o;
  logic                 is_sick_o;
  logic                 is_contagious_o;

  // Local copy of the registers, updated at each write transfer
  logic [DAY_W-1:0]     incubation_q;
  logic [DAY_W-1:0]     contagious_q;
  logic [DAY_W-1:0]     immunity_q;
  logic [Q_W-1:0]       escape_q;

  agent_result_t        pending_updates[$];

  bit                   no_idle       = 1'b0;
  int unsigned          n_errors      = 0;
  int unsigned          n_checked     = 0;
  int unsigned          n_sent        = 0;
  int unsigned          n_settings    = 1;
  int unsigned          n_infections  = 0;
  int unsigned          n_transitions = 0;
  int unsigned          idle_cycles   = 0;

  seirs_cell_update dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .status_i         (status_i),
    .days_in_status_i (days_in_status_i),
    .neighbour_mask_i (neighbour_mask_i),
    .random_value_i   (random_value_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .new_status_o     (new_status_o),
    .new_days_o       (new_days_o),
    .is_sick_o        (is_sick_o),
    .is_contagious_o  (is_contagious_o)
  );

  always #(CLK_HALF) clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Model of the daily step
  // --------------------------------------------------------------------------

  // Chance of infection in unsigned Q1.16: 1.0 - q^n, where q^n
  // is truncated after every multiply. No infectious neighbour gives zero.
  function automatic logic [16:0] infection_chance(logic [NBR_W-1:0] mask);
    logic [16:0] escape_pow;
    logic [32:0] product;
    escape_pow = 17'h10000;
    for (int k = 0; k < NBR_W; k++) begin
      if (mask[k]) begin
        product    = escape_pow * escape_q;
        escape_pow = product[32:16];
      end
    end
    return 17'h10000 - escape_pow;
  endfunction

  function automatic agent_result_t next_day(agent_rec_t r);
    agent_result_t o;
    logic [DAY_W-1:0] d;
    status_e s;
    // Count the day first; every transition test sees the new count
    d = (r.days == DAY_MAX) ? r.days : r.days + DAY_W'(1);
    s = r.st;
    case (r.st)
      ST_SUSCEPTIBLE: begin
        if ({1'b0, r.rnd} < infection_chance(r.mask)) begin
          s = ST_EXPOSED;
          d = '0;
        end
      end
      ST_EXPOSED: begin
        if (d >= incubation_q) begin
          s = ST_INFECTIOUS;
          d = '0;
        end
      end
      ST_INFECTIOUS: begin
        if (d >= contagious_q) begin
          s = ST_RECOVERED;
          d = '0;
        end
      end
      default: begin
        // Zero immunity: recovered for good
        if (immunity_q != '0 && d >= immunity_q) begin
          s = ST_SUSCEPTIBLE;
          d = '0;
        end
      end
    endcase
    o.st         = s;
    o.days       = d;
    o.sick       = (s == ST_EXPOSED) || (s == ST_INFECTIOUS);
    o.contagious = (s == ST_INFECTIOUS);
    return o;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  function automatic dir_row_t dir_row(logic [1:0] setting, status_e st,
                                       logic [DAY_W-1:0] days, logic [NBR_W-1:0] mask,
                                       logic [Q_W-1:0] rnd, logic typed, status_e ex_st,
                                       logic [DAY_W-1:0] ex_days, logic ex_sick,
                                       logic ex_cont);
    dir_row_t row;
    row.setting        = setting;
    row.rec            = '{st, days, mask, rnd};
    row.typed          = typed;
    row.res            = '{ex_st, ex_days, ex_sick, ex_cont};
    return row;
  endfunction

  // Durations lean toward small values so that all transitions show up often
  function automatic logic [DAY_W-1:0] pick_duration();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return DAY_MAX;
      2, 3:    return DAY_W'($urandom_range(1, 12));
      4:       return DAY_W'($urandom_range(13, 400));
      default: return DAY_W'($urandom);
    endcase
  endfunction

  function automatic cfg_set_t random_settings();
    cfg_set_t c;
    c.incubation = pick_duration();
    c.contagious = pick_duration();
    c.immunity   = pick_duration();
    case ($urandom_range(0, 4))
      0:       c.escape = '0;
      1:       c.escape = '1;
      2:       c.escape = Q_W'($urandom);
      default: c.escape = Q_W'($urandom_range(20000, 62000));
    endcase
    return c;
  endfunction

  // Random record aimed at the edges: counts next to the status threshold,
  // counts near saturation, and random values next to the infection chance
  function automatic agent_rec_t random_record();
    agent_rec_t r;
    logic [DAY_W-1:0] limit;
    logic [16:0] chance;
    r.st = status_e'($urandom_range(0, 3));
    case (r.st)
      ST_EXPOSED:    limit = incubation_q;
      ST_INFECTIOUS: limit = contagious_q;
      ST_RECOVERED:  limit = immunity_q;
      default:       limit = DAY_W'(1);
    endcase
    case ($urandom_range(0, 4))
      0:       r.days = limit - DAY_W'(1);
      1:       r.days = limit - DAY_W'($urandom_range(0, 2));
      2:       r.days = DAY_MAX - DAY_W'($urandom_range(0, 1));
      3:       r.days = DAY_W'($urandom_range(0, 20));
      default: r.days = DAY_W'($urandom);
    endcase
    case ($urandom_range(0, 3))
      0:       r.mask = NBR_W'(1) << $urandom_range(0, NBR_W - 1);
      1:       r.mask = ($urandom_range(0, 1) != 0) ? '1 : '0;
      default: r.mask = NBR_W'($urandom);
    endcase
    chance = infection_chance(r.mask);
    if ($urandom_range(0, 2) == 0) begin
      r.rnd = Q_W'(chance - 17'($urandom_range(0, 1)));
    end else begin
      r.rnd = Q_W'($urandom);
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Driving tasks
  // --------------------------------------------------------------------------

  // Present one record after a random gap, hold it until the transfer, then
  // queue its expected update. Valid stays high for a back-to-back record.
  task automatic send_record(agent_rec_t r, logic typed, agent_result_t typed_res);
    int unsigned gap;
    agent_result_t res;
    gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    status_i         <= r.st;
    days_in_status_i <= r.days;
    neighbour_mask_i <= r.mask;
    random_value_i   <= r.rnd;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    res = typed ? typed_res : next_day(r);
    if (res.st != r.st) begin
      n_transitions++;
    end
    if (r.st == ST_SUSCEPTIBLE && res.st == ST_EXPOSED) begin
      n_infections++;
    end
    pending_updates.push_back(res);
    n_sent++;
  endtask

  // Drop valid and wait until every queued update has come back
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_updates.size() != 0);
  endtask

  // Write all four registers back to back; valid stays high between writes
  task automatic load_settings(cfg_set_t c);
    logic [CFG_IDX_W-1:0] idx [4];
    logic [DAY_W-1:0] val [4];
    idx[0] = CFG_INCUBATION;  val[0] = c.incubation;
    idx[1] = CFG_CONTAGIOUS;  val[1] = c.contagious;
    idx[2] = CFG_IMMUNITY;    val[2] = c.immunity;
    idx[3] = CFG_ESCAPE;      val[3] = c.escape;
    for (int k = 0; k < 4; k++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx[k];
      cfg_data_i  <= val[k];
      do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
      case (idx[k])
        CFG_INCUBATION: incubation_q = val[k];
        CFG_CONTAGIOUS: contagious_q = val[k];
        CFG_IMMUNITY:   immunity_q   = val[k];
        CFG_ESCAPE:     escape_q     = Q_W'(val[k]);
        default: ;
      endcase
    end
    cfg_valid_i <= 1'b0;
    n_settings++;
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    cfg_set_t    settings [3];
    dir_row_t    dir_rows [$];
    logic [1:0]  cur_setting;

    // Setting 0 is the reset state; 1 has zero durations, one day of immunity
    // and certain infection; 2 has every register at its maximum
    settings[0] = '{INCUBATION_RST, CONTAGIOUS_RST, IMMUNITY_RST, ESCAPE_RST};
    settings[1] = '{DAY_W'(0), DAY_W'(0), DAY_W'(1), Q_W'(0)};
    settings[2] = '{DAY_MAX, DAY_MAX, DAY_MAX, '1};

    incubation_q = INCUBATION_RST;
    contagious_q = CONTAGIOUS_RST;
    immunity_q   = IMMUNITY_RST;
    escape_q     = ESCAPE_RST;

    // Under reset settings: no neighbours, saturation, full neighbourhood
    dir_rows.push_back(dir_row(0, ST_SUSCEPTIBLE, 0, 8'h00, 0, 1, ST_SUSCEPTIBLE, 1, 0, 0));
    dir_rows.push_back(dir_row(0, ST_SUSCEPTIBLE, DAY_MAX, 8'h00, '1, 1,
                               ST_SUSCEPTIBLE, DAY_MAX, 0, 0));
    dir_rows.push_back(dir_row(0, ST_SUSCEPTIBLE, 10, 8'hFF, 0, 1, ST_EXPOSED, 0, 1, 0));
    dir_rows.push_back(dir_row(0, ST_SUSCEPTIBLE, 10, 8'hFF, '1, 0, ST_SUSCEPTIBLE, 0, 0, 0));
    // One neighbour: the chance is 25786, probe both sides of it
    dir_rows.push_back(dir_row(0, ST_SUSCEPTIBLE, 3, 8'h01, 25785, 0, ST_SUSCEPTIBLE, 0, 0, 0));
    dir_rows.push_back(dir_row(0, ST_SUSCEPTIBLE, 3, 8'h01, 25786, 0, ST_SUSCEPTIBLE, 0, 0, 0));
    dir_rows.push_back(dir_row(0, ST_SUSCEPTIBLE, 3, 8'h80, 12345, 0, ST_SUSCEPTIBLE, 0, 0, 0));
    dir_rows.push_back(dir_row(0, ST_SUSCEPTIBLE, 200, 8'h55, 40000, 0,
                               ST_SUSCEPTIBLE, 0, 0, 0));
    // Exposed and infectious around their thresholds, mask ignored
    dir_rows.push_back(dir_row(0, ST_EXPOSED, 3, 8'hFF, 0, 1, ST_EXPOSED, 4, 1, 0));
    dir_rows.push_back(dir_row(0, ST_EXPOSED, 4, 8'h00, '1, 1, ST_INFECTIOUS, 0, 1, 1));
    dir_rows.push_back(dir_row(0, ST_EXPOSED, DAY_MAX, 8'h00, 0, 1, ST_INFECTIOUS, 0, 1, 1));
    dir_rows.push_back(dir_row(0, ST_INFECTIOUS, 5, 8'h00, 0, 1, ST_INFECTIOUS, 6, 1, 1));
    dir_rows.push_back(dir_row(0, ST_INFECTIOUS, 6, 8'h00, 0, 1, ST_RECOVERED, 0, 0, 0));
    dir_rows.push_back(dir_row(0, ST_INFECTIOUS, DAY_MAX, 8'h00, 0, 1, ST_RECOVERED, 0, 0, 0));
    // Permanent immunity, also at the saturated count
    dir_rows.push_back(dir_row(0, ST_RECOVERED, 100, 8'hFF, 0, 1, ST_RECOVERED, 101, 0, 0));
    dir_rows.push_back(dir_row(0, ST_RECOVERED, DAY_MAX, 8'h00, 0, 1,
                               ST_RECOVERED, DAY_MAX, 0, 0));
    // Zero durations and one day of immunity move on the same day; zero escape factor infects with any neighbour
    dir_rows.push_back(dir_row(1, ST_EXPOSED, 0, 8'h00, 0, 1, ST_INFECTIOUS, 0, 1, 1));
    dir_rows.push_back(dir_row(1, ST_INFECTIOUS, 0, 8'h00, 0, 1, ST_RECOVERED, 0, 0, 0));
    dir_rows.push_back(dir_row(1, ST_RECOVERED, 0, 8'h00, 0, 1, ST_SUSCEPTIBLE, 0, 0, 0));
    dir_rows.push_back(dir_row(1, ST_SUSCEPTIBLE, 0, 8'h01, '1, 1, ST_EXPOSED, 0, 1, 0));
    dir_rows.push_back(dir_row(1, ST_SUSCEPTIBLE, 0, 8'h00, 0, 1, ST_SUSCEPTIBLE, 1, 0, 0));
    // Maximum durations reached only through saturation; q just below 1.0
    dir_rows.push_back(dir_row(2, ST_EXPOSED, DAY_MAX - 1, 8'hAA, 1, 0, ST_EXPOSED, 0, 0, 0));
    dir_rows.push_back(dir_row(2, ST_RECOVERED, DAY_MAX, 8'h00, 0, 0, ST_RECOVERED, 0, 0, 0));
    dir_rows.push_back(dir_row(2, ST_RECOVERED, DAY_MAX - 2, 8'h00, 0, 0,
                               ST_RECOVERED, 0, 0, 0));
    dir_rows.push_back(dir_row(2, ST_SUSCEPTIBLE, 7, 8'hFF, 0, 0, ST_SUSCEPTIBLE, 0, 0, 0));

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table; switch settings only with the pipeline empty
    cur_setting = 2'd0;
    foreach (dir_rows[k]) begin
      if (dir_rows[k].setting != cur_setting) begin
        drain();
        load_settings(settings[dir_rows[k].setting]);
        cur_setting = dir_rows[k].setting;
      end
      send_record(dir_rows[k].rec, dir_rows[k].typed, dir_rows[k].res);
    end

    // Random phases, each under new settings; some run without any idling
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      drain();
      load_settings(random_settings());
      no_idle = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < PHASE_RECORDS; i++) begin
        send_record(random_record(), 1'b0, '0);
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("seirs_cell_update_tb: %0d records sent, %0d results checked, %0d settings",
             n_sent, n_checked, n_settings);
    $display("seirs_cell_update_tb: %0d infections, %0d status changes in total",
             n_infections, n_transitions);
    if (n_errors == 0) begin
      $display("seirs_cell_update_tb: PASS");
    end else begin
      $display("seirs_cell_update_tb: FAIL");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Result sink: random stall before each transfer
  // --------------------------------------------------------------------------
  initial begin : sink
    int unsigned stall;
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, MAX_GAP);
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o === 1'b1 && out_ready_i === 1'b1));
    end
  end

  // --------------------------------------------------------------------------
  // Checker: compare each result transfer with the oldest pending update
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    agent_result_t want;
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_ready_i === 1'b1) begin
      if (pending_updates.size() == 0) begin
        $error("result with no record pending: new_status %0d new_days %0d",
               new_status_o, new_days_o);
        n_errors++;
      end else begin
        want = pending_updates.pop_front();
        n_checked++;
        if (new_status_o !== want.st) begin
          $error("new_status: expected %0d, got %0d", want.st, new_status_o);
          n_errors++;
        end
        if (new_days_o !== want.days) begin
          $error("new_days: expected %0d, got %0d", want.days, new_days_o);
          n_errors++;
        end
        if (is_sick_o !== want.sick) begin
          $error("is_sick: expected %0d, got %0d", want.sick, is_sick_o);
          n_errors++;
        end
        if (is_contagious_o !== want.contagious) begin
          $error("is_contagious: expected %0d, got %0d", want.contagious, is_contagious_o);
          n_errors++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: end the run when no channel moves for too long
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni !== 1'b1
        || (in_valid_i === 1'b1 && in_ready_o === 1'b1)
        || (out_valid_o === 1'b1 && out_ready_i === 1'b1)
        || (cfg_valid_i === 1'b1 && cfg_ready_o === 1'b1)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("seirs_cell_update_tb: no transfer for %0d cycles, %0d updates pending",
               idle_cycles, pending_updates.size());
      $display("seirs_cell_update_tb: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

@@ filelist.f @@
+incdir+src
src/seirs_pkg.sv
src/seirs_pow_table.sv
src/seirs_cell_update.sv
src/seirs_checker.sv
tb/seirs_cell_update_tb.sv
